/* hw/rtl/cpe_pkg.sv */
// Package for the 6502 instruction execute core.
// Holds opcode codes, flag masks, payload structs and shared types; no dependencies.
package cpe_pkg;

  localparam int unsigned StackDepth = 256;
  localparam int unsigned AddrBits   = 3;

  localparam logic [5:0] OP_ADC = 6'd0;
  localparam logic [5:0] OP_AND = 6'd1;
  localparam logic [5:0] OP_ASL = 6'd2;
  localparam logic [5:0] OP_BCC = 6'd3;
  localparam logic [5:0] OP_BCS = 6'd4;
  localparam logic [5:0] OP_BEQ = 6'd5;
  localparam logic [5:0] OP_BIT = 6'd6;
  localparam logic [5:0] OP_BMI = 6'd7;
  localparam logic [5:0] OP_BNE = 6'd8;
  localparam logic [5:0] OP_BPL = 6'd9;
  localparam logic [5:0] OP_BRK = 6'd10;
  localparam logic [5:0] OP_BVC = 6'd11;
  localparam logic [5:0] OP_BVS = 6'd12;
  localparam logic [5:0] OP_CLC = 6'd13;
  localparam logic [5:0] OP_CLD = 6'd14;
  localparam logic [5:0] OP_CLI = 6'd15;
  localparam logic [5:0] OP_CLV = 6'd16;
  localparam logic [5:0] OP_CMP = 6'd17;
  localparam logic [5:0] OP_CPX = 6'd18;
  localparam logic [5:0] OP_CPY = 6'd19;
  localparam logic [5:0] OP_DEC = 6'd20;
  localparam logic [5:0] OP_DEX = 6'd21;
  localparam logic [5:0] OP_DEY = 6'd22;
  localparam logic [5:0] OP_EOR = 6'd23;
  localparam logic [5:0] OP_INC = 6'd24;
  localparam logic [5:0] OP_INX = 6'd25;
  localparam logic [5:0] OP_INY = 6'd26;
  localparam logic [5:0] OP_JMP = 6'd27;
  localparam logic [5:0] OP_JSR = 6'd28;
  localparam logic [5:0] OP_LDA = 6'd29;
  localparam logic [5:0] OP_LDX = 6'd30;
  localparam logic [5:0] OP_LDY = 6'd31;
  localparam logic [5:0] OP_LSR = 6'd32;
  localparam logic [5:0] OP_NOP = 6'd33;
  localparam logic [5:0] OP_ORA = 6'd34;
  localparam logic [5:0] OP_PHA = 6'd35;
  localparam logic [5:0] OP_PHP = 6'd36;
  localparam logic [5:0] OP_PLA = 6'd37;
  localparam logic [5:0] OP_PLP = 6'd38;
  localparam logic [5:0] OP_ROL = 6'd39;
  localparam logic [5:0] OP_ROR = 6'd40;
  localparam logic [5:0] OP_RTI = 6'd41;
  localparam logic [5:0] OP_RTS = 6'd42;
  localparam logic [5:0] OP_SBC = 6'd43;
  localparam logic [5:0] OP_SEC = 6'd44;
  localparam logic [5:0] OP_SED = 6'd45;
  localparam logic [5:0] OP_SEI = 6'd46;
  localparam logic [5:0] OP_STA = 6'd47;
  localparam logic [5:0] OP_STX = 6'd48;
  localparam logic [5:0] OP_STY = 6'd49;
  localparam logic [5:0] OP_TAX = 6'd50;
  localparam logic [5:0] OP_TAY = 6'd51;
  localparam logic [5:0] OP_TSX = 6'd52;
  localparam logic [5:0] OP_TXA = 6'd53;
  localparam logic [5:0] OP_TXS = 6'd54;
  localparam logic [5:0] OP_TYA = 6'd55;

  localparam int unsigned FC = 0;
  localparam int unsigned FZ = 1;
  localparam int unsigned FI = 2;
  localparam int unsigned FD = 3;
  localparam int unsigned FB = 4;
  localparam int unsigned FU = 5;
  localparam int unsigned FV = 6;
  localparam int unsigned FN = 7;

  localparam logic [7:0] PushMask = 8'h30;
  localparam logic [7:0] SpReset  = 8'hFD;
  localparam logic [7:0] PReset   = 8'h24;

  localparam logic [AddrBits-1:0] REG_BRK_VECTOR = 3'd0;

  typedef struct packed {
    logic [5:0]  opcode;
    logic [7:0]  operand;
    logic [15:0] effective_address;
    logic        accumulator_mode;
    logic [15:0] next_pc;
  } item_t;

  typedef struct packed {
    logic        write_enable;
    logic [15:0] write_address;
    logic [7:0]  write_data;
    logic [15:0] new_pc;
    logic [7:0]  flags_out;
    logic [7:0]  acc_out;
    logic [7:0]  x_out;
    logic [7:0]  y_out;
    logic [7:0]  sp_out;
  } result_t;

  typedef struct packed {
    logic [7:0] a;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] sp;
    logic [7:0] p;
  } regs_t;

  typedef struct packed {
    logic       wr;
    logic       rd;
    logic [7:0] addr;
    logic [7:0] wdata;
  } stk_req_t;

endpackage

/* hw/rtl/cpe_ram.sv */
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
module cpe_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

/* hw/rtl/cpe_exec.sv */
// Execute logic: next register values, result and stack access for each step.
// Depends on cpe_pkg.
module cpe_exec import cpe_pkg::*; (
  input  item_t       cur,
  input  regs_t       regs,
  input  logic [1:0]  step,
  input  logic [7:0]  b0,
  input  logic [7:0]  b1,
  input  logic [7:0]  rd,
  input  logic [15:0] brk_vector,
  output regs_t       regs_next,
  output result_t     res,
  output logic [1:0]  last,
  output stk_req_t    req
);

  function automatic logic [7:0] set_nz(input logic [7:0] p, input logic [7:0] v);
    logic [7:0] q;
    q     = p;
    q[FZ] = (v == 8'd0);
    q[FN] = v[7];
    return q;
  endfunction

  always_comb begin
    logic [7:0]  m;
    logic [7:0]  m2;
    logic [8:0]  sum;
    logic [7:0]  cr;
    logic [8:0]  diff;
    logic [7:0]  sv;
    logic [7:0]  shv;
    logic        shc;
    logic [15:0] pc;
    logic [15:0] jt;
    logic [15:0] btgt;
    logic [7:0]  pushp;
    logic [7:0]  pullp;
    logic [7:0]  push_addr;
    logic [7:0]  pull_addr;
    logic        we;
    logic [7:0]  wd;

    m         = cur.operand;
    m2        = (cur.opcode == OP_SBC) ? ~m : m;
    sum       = {1'b0, regs.a} + {1'b0, m2} + {8'd0, regs.p[FC]};
    cr        = (cur.opcode == OP_CPX) ? regs.x : ((cur.opcode == OP_CPY) ? regs.y : regs.a);
    diff      = {1'b0, cr} - {1'b0, m};
    sv        = cur.accumulator_mode ? regs.a : m;
    pc        = cur.next_pc;
    jt        = pc - 16'd1;
    btgt      = pc + {{8{m[7]}}, m};
    pushp     = regs.p | PushMask;
    push_addr = regs.sp - {6'd0, step};
    pull_addr = regs.sp + {6'd0, step} + 8'd1;
    pullp     = (((step == 2'd1) ? rd : b0) & ~PushMask) | (regs.p & PushMask);
    we        = 1'b0;
    wd        = 8'd0;
    shv       = 8'd0;
    shc       = 1'b0;
    regs_next = regs;
    last      = 2'd0;
    req       = '0;

    unique case (cur.opcode)
      OP_ADC, OP_SBC: begin
        regs_next.a     = sum[7:0];
        regs_next.p     = set_nz(regs.p, sum[7:0]);
        regs_next.p[FC] = sum[8];
        regs_next.p[FV] = (sum[7] ^ regs.a[7]) & (sum[7] ^ m2[7]);
      end
      OP_AND: begin
        regs_next.a = regs.a & m;
        regs_next.p = set_nz(regs.p, regs.a & m);
      end
      OP_EOR: begin
        regs_next.a = regs.a ^ m;
        regs_next.p = set_nz(regs.p, regs.a ^ m);
      end
      OP_ORA: begin
        regs_next.a = regs.a | m;
        regs_next.p = set_nz(regs.p, regs.a | m);
      end
      OP_ASL, OP_LSR, OP_ROL, OP_ROR: begin
        case (cur.opcode)
          OP_ASL: begin
            shc = sv[7];
            shv = {sv[6:0], 1'b0};
          end
          OP_ROL: begin
            shc = sv[7];
            shv = {sv[6:0], regs.p[FC]};
          end
          OP_LSR: begin
            shc = sv[0];
            shv = {1'b0, sv[7:1]};
          end
          default: begin
            shc = sv[0];
            shv = {regs.p[FC], sv[7:1]};
          end
        endcase
        regs_next.p     = set_nz(regs.p, shv);
        regs_next.p[FC] = shc;
        if (cur.accumulator_mode) begin
          regs_next.a = shv;
        end else begin
          we = 1'b1;
          wd = shv;
        end
      end
      OP_BCC: pc = regs.p[FC] ? pc : btgt;
      OP_BCS: pc = regs.p[FC] ? btgt : pc;
      OP_BEQ: pc = regs.p[FZ] ? btgt : pc;
      OP_BNE: pc = regs.p[FZ] ? pc : btgt;
      OP_BMI: pc = regs.p[FN] ? btgt : pc;
      OP_BPL: pc = regs.p[FN] ? pc : btgt;
      OP_BVS: pc = regs.p[FV] ? btgt : pc;
      OP_BVC: pc = regs.p[FV] ? pc : btgt;
      OP_BIT: begin
        regs_next.p[FZ] = ((regs.a & m) == 8'd0);
        regs_next.p[FV] = m[6];
        regs_next.p[FN] = m[7];
      end
      OP_BRK: begin
        last      = 2'd2;
        req.wr    = 1'b1;
        req.addr  = push_addr;
        case (step)
          2'd0:    req.wdata = pc[15:8];
          2'd1:    req.wdata = pc[7:0];
          default: req.wdata = pushp;
        endcase
        regs_next.sp    = regs.sp - 8'd3;
        regs_next.p[FB] = 1'b0;
        regs_next.p[FI] = 1'b1;
        pc              = brk_vector;
      end
      OP_CLC: regs_next.p[FC] = 1'b0;
      OP_CLD: regs_next.p[FD] = 1'b0;
      OP_CLI: regs_next.p[FI] = 1'b0;
      OP_CLV: regs_next.p[FV] = 1'b0;
      OP_SEC: regs_next.p[FC] = 1'b1;
      OP_SED: regs_next.p[FD] = 1'b1;
      OP_SEI: regs_next.p[FI] = 1'b1;
      OP_CMP, OP_CPX, OP_CPY: begin
        regs_next.p[FC] = ~diff[8];
        regs_next.p[FZ] = (cr == m);
        regs_next.p[FN] = diff[7];
      end
      OP_DEC: begin
        regs_next.p = set_nz(regs.p, m - 8'd1);
        we          = 1'b1;
        wd          = m - 8'd1;
      end
      OP_INC: begin
        regs_next.p = set_nz(regs.p, m + 8'd1);
        we          = 1'b1;
        wd          = m + 8'd1;
      end
      OP_DEX: begin
        regs_next.x = regs.x - 8'd1;
        regs_next.p = set_nz(regs.p, regs.x - 8'd1);
      end
      OP_DEY: begin
        regs_next.y = regs.y - 8'd1;
        regs_next.p = set_nz(regs.p, regs.y - 8'd1);
      end
      OP_INX: begin
        regs_next.x = regs.x + 8'd1;
        regs_next.p = set_nz(regs.p, regs.x + 8'd1);
      end
      OP_INY: begin
        regs_next.y = regs.y + 8'd1;
        regs_next.p = set_nz(regs.p, regs.y + 8'd1);
      end
      OP_JMP: pc = cur.effective_address;
      OP_JSR: begin
        last         = 2'd1;
        req.wr       = 1'b1;
        req.addr     = push_addr;
        req.wdata    = (step == 2'd0) ? jt[15:8] : jt[7:0];
        regs_next.sp = regs.sp - 8'd2;
        pc           = cur.effective_address;
      end
      OP_LDA: begin
        regs_next.a = m;
        regs_next.p = set_nz(regs.p, m);
      end
      OP_LDX: begin
        regs_next.x = m;
        regs_next.p = set_nz(regs.p, m);
      end
      OP_LDY: begin
        regs_next.y = m;
        regs_next.p = set_nz(regs.p, m);
      end
      OP_PHA, OP_PHP: begin
        req.wr       = 1'b1;
        req.addr     = push_addr;
        req.wdata    = (cur.opcode == OP_PHA) ? regs.a : pushp;
        regs_next.sp = regs.sp - 8'd1;
      end
      OP_PLA: begin
        last         = 2'd1;
        req.rd       = (step == 2'd0);
        req.addr     = pull_addr;
        regs_next.sp = regs.sp + 8'd1;
        regs_next.a  = rd;
        regs_next.p  = set_nz(regs.p, rd);
      end
      OP_PLP: begin
        last         = 2'd1;
        req.rd       = (step == 2'd0);
        req.addr     = pull_addr;
        regs_next.sp = regs.sp + 8'd1;
        regs_next.p  = pullp;
      end
      OP_RTS: begin
        last         = 2'd2;
        req.rd       = (step != 2'd2);
        req.addr     = pull_addr;
        regs_next.sp = regs.sp + 8'd2;
        pc           = {rd, b0} + 16'd1;
      end
      OP_RTI: begin
        last         = 2'd3;
        req.rd       = (step != 2'd3);
        req.addr     = pull_addr;
        regs_next.sp = regs.sp + 8'd3;
        regs_next.p  = pullp;
        pc           = {rd, b1};
      end
      OP_STA: begin
        we = 1'b1;
        wd = regs.a;
      end
      OP_STX: begin
        we = 1'b1;
        wd = regs.x;
      end
      OP_STY: begin
        we = 1'b1;
        wd = regs.y;
      end
      OP_TAX: begin
        regs_next.x = regs.a;
        regs_next.p = set_nz(regs.p, regs.a);
      end
      OP_TAY: begin
        regs_next.y = regs.a;
        regs_next.p = set_nz(regs.p, regs.a);
      end
      OP_TSX: begin
        regs_next.x = regs.sp;
        regs_next.p = set_nz(regs.p, regs.sp);
      end
      OP_TXA: begin
        regs_next.a = regs.x;
        regs_next.p = set_nz(regs.p, regs.x);
      end
      OP_TXS: regs_next.sp = regs.x;
      OP_TYA: begin
        regs_next.a = regs.y;
        regs_next.p = set_nz(regs.p, regs.y);
      end
      default: begin
      end
    endcase

    res.write_enable  = we;
    res.write_address = we ? cur.effective_address : 16'd0;
    res.write_data    = wd;
    res.new_pc        = pc;
    res.flags_out     = regs_next.p;
    res.acc_out       = regs_next.a;
    res.x_out         = regs_next.x;
    res.y_out         = regs_next.y;
    res.sp_out        = regs_next.sp;
  end

endmodule

/* hw/rtl/cpe_outq.sv */
// Two-entry result queue between the execute sequencer and the result channel.
// Depends on cpe_pkg.
module cpe_outq import cpe_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    full,
  output logic    pop,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  result_t    slot [2];
  logic [1:0] count;
  logic       rptr;
  logic       wptr;

  assign result_valid = (count != 2'd0);
  assign result       = slot[rptr];
  assign pop          = result_valid && !result_stall;
  assign full         = (count == 2'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
      rptr  <= 1'b0;
      wptr  <= 1'b0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
    if (push) begin
      slot[wptr] <= push_data;
    end
  end

endmodule

/* hw/rtl/cpu6502_instruction_execute_core.sv */
// 6502 instruction execute core: one decoded instruction per transaction.
// JSR, PLA, PLP, BRK, RTS and RTI run as a sequence of steps, as the stack
// RAM has a single port. A result goes through the result queue, and a new
// transaction is taken only as the current one finishes; a full queue holds both.
// Reset (rst, synchronous) clears A/X/Y, loads SP 0xFD and status 0x24, and
// clears the stack valid bits at once, so no clearing pass is needed.
module cpu6502_instruction_execute_core import cpe_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  item_t               item,
  output logic                result_valid,
  input  logic                result_stall,
  output result_t             result,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [AddrBits-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  // The current instruction sits in cur while its steps run. Architectural
  // registers change only at the final step, so each step addresses the stack
  // relative to the SP the instruction started with.
  item_t       cur;
  logic        cur_valid;
  logic [1:0]  step;
  logic [7:0]  b0;
  logic [7:0]  b1;
  regs_t       regs;
  logic [15:0] brk_vector;

  regs_t       regs_next;
  result_t     res;
  logic [1:0]  last;
  stk_req_t    req;

  logic        q_full;
  logic        q_pop;
  logic        finish;
  logic        advance;
  logic        accept;

  // Stack page: RAM plus one valid bit per entry. An entry that was never
  // written reads as zero, which matches the cleared page after reset.
  logic            ram_we;
  logic            ram_re;
  logic [7:0]      ram_q;
  logic [StackDepth-1:0] vld;
  logic            vld_q;
  logic [7:0]      rd;

  assign rd = vld_q ? ram_q : 8'd0;

  cpe_exec u_exec (
    .cur        (cur),
    .regs       (regs),
    .step       (step),
    .b0         (b0),
    .b1         (b1),
    .rd         (rd),
    .brk_vector (brk_vector),
    .regs_next  (regs_next),
    .res        (res),
    .last       (last),
    .req        (req)
  );

  // The last step may wait for queue space; earlier steps always move on.
  // Reads are issued only on earlier steps, so the read data holds while
  // the final step waits.
  assign finish     = cur_valid && (step == last) && (!q_full || q_pop);
  assign advance    = cur_valid && (step != last);
  assign item_stall = cur_valid && !finish;
  assign accept     = item_valid && !item_stall;
  assign ram_we     = cur_valid && req.wr && ((step != last) || finish);
  assign ram_re     = cur_valid && req.rd;

  cpe_ram #(
    .WIDTH (8),
    .DEPTH (StackDepth)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (req.addr),
    .wdata (req.wdata),
    .rdata (ram_q)
  );

  cpe_outq u_outq (
    .clk          (clk),
    .rst          (rst),
    .push         (finish),
    .push_data    (res),
    .full         (q_full),
    .pop          (q_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid  <= 1'b0;
      step       <= 2'd0;
      regs.a     <= 8'd0;
      regs.x     <= 8'd0;
      regs.y     <= 8'd0;
      regs.sp    <= SpReset;
      regs.p     <= PReset;
      brk_vector <= 16'd0;
      vld        <= '0;
      vld_q      <= 1'b0;
    end else begin
      if (accept) begin
        cur_valid <= 1'b1;
      end else if (finish) begin
        cur_valid <= 1'b0;
      end
      if (finish) begin
        regs <= regs_next;
        step <= 2'd0;
      end else if (advance) begin
        step <= step + 2'd1;
      end
      if (ram_we) begin
        vld[req.addr] <= 1'b1;
      end
      if (ram_re) begin
        vld_q <= vld[req.addr];
      end
      if (psel && penable && pwrite && paddr[AddrBits-1:2] == REG_BRK_VECTOR[AddrBits-1:2]) begin
        brk_vector <= pwdata[15:0];
      end
    end
    if (accept) begin
      cur <= item;
    end
    // Pulled bytes come out of the registered RAM read; keep the early ones as later reads follow.
    if (advance && step == 2'd1) begin
      b0 <= rd;
    end
    if (advance && step == 2'd2) begin
      b1 <= rd;
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[AddrBits-1:2] == REG_BRK_VECTOR[AddrBits-1:2]) ?
                  {16'd0, brk_vector} : 32'd0;

endmodule

/* hw/rtl/cpe_checker.sv */
// Port-level checker for the 6502 execute core, bound to the top level.
// Depends on cpe_pkg and cpu6502_instruction_execute_core.
module cpe_checker import cpe_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    result_valid,
  input logic    result_stall,
  input result_t result,
  input logic    pready
);

  a_pready: assert property (@(posedge clk) pready)
    else $error("pready dropped");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

  a_reset: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result offered after reset");

  a_nowrite: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.write_enable |->
      result.write_address == 16'd0 && result.write_data == 8'd0)
    else $error("write fields set without write");

  a_bit5: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.flags_out[FU])
    else $error("status bit 5 clear");

endmodule

bind cpu6502_instruction_execute_core cpe_checker u_cpe_checker (.*);

/* dv/cpu6502_instruction_execute_core_tb.sv */
// Self-checking testbench for the 6502 instruction execute core.
// Depends on cpe_pkg and cpu6502_instruction_execute_core, with the files that the core instantiates.
`timescale 1ns / 1ps

module cpu6502_instruction_execute_core_tb;
  import cpe_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  item_t item = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  result_t result;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [AddrBits-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  always #2 clk = ~clk;

  cpu6502_instruction_execute_core DUT (.*);

  // Shadow copy of the architectural state, updated as each transaction is accepted.
  logic [7:0] sh_a, sh_x, sh_y, sh_sp, sh_p;
  logic [7:0] sh_stack [256];
  logic [15:0] sh_brk_vec;

  result_t expected_results[$];
  int unsigned mismatch_count = 0;
  bit quiet_mode = 1'b0;  // When set, neither side idles.

  function automatic void set_nz(input logic [7:0] v);
    sh_p[FZ] = (v == 8'h00);
    sh_p[FN] = v[7];
  endfunction

  function automatic void push8(input logic [7:0] v);
    sh_stack[sh_sp] = v;
    sh_sp = sh_sp - 8'd1;
  endfunction

  function automatic logic [7:0] pull8();
    sh_sp = sh_sp + 8'd1;
    return sh_stack[sh_sp];
  endfunction

  function automatic void add_carry(input logic [7:0] m);
    logic [8:0] t;
    t = {1'b0, sh_a} + {1'b0, m} + {8'd0, sh_p[FC]};
    sh_p[FC] = t[8];
    sh_p[FV] = (t[7] ^ sh_a[7]) & (t[7] ^ m[7]);
    sh_a = t[7:0];
    set_nz(sh_a);
  endfunction

  function automatic void compare_to(input logic [7:0] r, input logic [7:0] m);
    logic [7:0] d;
    d = r - m;
    sh_p[FC] = (r >= m);
    sh_p[FZ] = (r == m);
    sh_p[FN] = d[7];
  endfunction

  function automatic void pull_status();
    logic [7:0] keep, v;
    keep = sh_p & PushMask;
    v = pull8();
    sh_p = (v & ~PushMask) | keep;
  endfunction

  // Executes one instruction on the shadow state and returns the result it should produce.
  function automatic result_t execute_instruction(input item_t it);
    result_t r;
    logic [7:0] v, m;
    logic [15:0] pc, t;
    logic cin, take, is_branch;
    m = it.operand;
    pc = it.next_pc;
    r = '0;
    take = 1'b0;
    is_branch = 1'b0;
    case (it.opcode)
      OP_ADC: add_carry(m);
      OP_SBC: add_carry(~m);
      OP_AND: begin sh_a = sh_a & m; set_nz(sh_a); end
      OP_EOR: begin sh_a = sh_a ^ m; set_nz(sh_a); end
      OP_ORA: begin sh_a = sh_a | m; set_nz(sh_a); end
      OP_ASL, OP_LSR, OP_ROL, OP_ROR: begin
        v = it.accumulator_mode ? sh_a : m;
        cin = sh_p[FC];
        case (it.opcode)
          OP_ASL: begin sh_p[FC] = v[7]; v = {v[6:0], 1'b0}; end
          OP_LSR: begin sh_p[FC] = v[0]; v = {1'b0, v[7:1]}; end
          OP_ROL: begin sh_p[FC] = v[7]; v = {v[6:0], cin}; end
          default: begin sh_p[FC] = v[0]; v = {cin, v[7:1]}; end
        endcase
        set_nz(v);
        if (it.accumulator_mode) sh_a = v;
        else begin r.write_enable = 1'b1; r.write_data = v; end
      end
      OP_BCC: begin is_branch = 1'b1; take = !sh_p[FC]; end
      OP_BCS: begin is_branch = 1'b1; take = sh_p[FC]; end
      OP_BEQ: begin is_branch = 1'b1; take = sh_p[FZ]; end
      OP_BMI: begin is_branch = 1'b1; take = sh_p[FN]; end
      OP_BNE: begin is_branch = 1'b1; take = !sh_p[FZ]; end
      OP_BPL: begin is_branch = 1'b1; take = !sh_p[FN]; end
      OP_BVC: begin is_branch = 1'b1; take = !sh_p[FV]; end
      OP_BVS: begin is_branch = 1'b1; take = sh_p[FV]; end
      OP_BIT: begin
        sh_p[FZ] = ((sh_a & m) == 8'h00);
        sh_p[FV] = m[6];
        sh_p[FN] = m[7];
      end
      OP_BRK: begin
        push8(pc[15:8]);
        push8(pc[7:0]);
        push8(sh_p | PushMask);
        sh_p[FB] = 1'b0;
        sh_p[FI] = 1'b1;
        pc = sh_brk_vec;
      end
      OP_CLC: sh_p[FC] = 1'b0;
      OP_CLD: sh_p[FD] = 1'b0;
      OP_CLI: sh_p[FI] = 1'b0;
      OP_CLV: sh_p[FV] = 1'b0;
      OP_SEC: sh_p[FC] = 1'b1;
      OP_SED: sh_p[FD] = 1'b1;
      OP_SEI: sh_p[FI] = 1'b1;
      OP_CMP: compare_to(sh_a, m);
      OP_CPX: compare_to(sh_x, m);
      OP_CPY: compare_to(sh_y, m);
      OP_DEC: begin v = m - 8'd1; set_nz(v); r.write_enable = 1'b1; r.write_data = v; end
      OP_INC: begin v = m + 8'd1; set_nz(v); r.write_enable = 1'b1; r.write_data = v; end
      OP_DEX: begin sh_x = sh_x - 8'd1; set_nz(sh_x); end
      OP_DEY: begin sh_y = sh_y - 8'd1; set_nz(sh_y); end
      OP_INX: begin sh_x = sh_x + 8'd1; set_nz(sh_x); end
      OP_INY: begin sh_y = sh_y + 8'd1; set_nz(sh_y); end
      OP_JMP: pc = it.effective_address;
      OP_JSR: begin
        t = pc - 16'd1;
        push8(t[15:8]);
        push8(t[7:0]);
        pc = it.effective_address;
      end
      OP_LDA: begin sh_a = m; set_nz(m); end
      OP_LDX: begin sh_x = m; set_nz(m); end
      OP_LDY: begin sh_y = m; set_nz(m); end
      OP_PHA: push8(sh_a);
      OP_PHP: push8(sh_p | PushMask);
      OP_PLA: begin sh_a = pull8(); set_nz(sh_a); end
      OP_PLP: pull_status();
      OP_RTI: begin
        pull_status();
        t[7:0] = pull8();
        t[15:8] = pull8();
        pc = t;
      end
      OP_RTS: begin
        t[7:0] = pull8();
        t[15:8] = pull8();
        pc = t + 16'd1;
      end
      OP_STA: begin r.write_enable = 1'b1; r.write_data = sh_a; end
      OP_STX: begin r.write_enable = 1'b1; r.write_data = sh_x; end
      OP_STY: begin r.write_enable = 1'b1; r.write_data = sh_y; end
      OP_TAX: begin sh_x = sh_a; set_nz(sh_x); end
      OP_TAY: begin sh_y = sh_a; set_nz(sh_y); end
      OP_TSX: begin sh_x = sh_sp; set_nz(sh_x); end
      OP_TXA: begin sh_a = sh_x; set_nz(sh_a); end
      OP_TXS: sh_sp = sh_x;
      OP_TYA: begin sh_a = sh_y; set_nz(sh_a); end
      default: ;
    endcase
    // A taken branch adds the sign-extended offset and wraps at 16 bits.
    if (is_branch && take) pc = pc + {{8{m[7]}}, m};
    if (r.write_enable) r.write_address = it.effective_address;
    r.new_pc = pc;
    r.flags_out = sh_p;
    r.acc_out = sh_a;
    r.x_out = sh_x;
    r.y_out = sh_y;
    r.sp_out = sh_sp;
    return r;
  endfunction

  // Offers one transaction, with a random idle gap ahead of it, and waits until it is taken.
  task automatic send_instruction(input item_t it);
    while (!quiet_mode && $urandom_range(99) < 11) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item <= it;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    expected_results.push_back(execute_instruction(it));
    @(negedge clk);
  endtask

  task automatic send_op(input logic [5:0] op, input logic [7:0] m);
    item_t it;
    it.opcode = op;
    it.operand = m;
    it.effective_address = 16'($urandom);
    it.accumulator_mode = 1'($urandom);
    it.next_pc = 16'($urandom);
    send_instruction(it);
  endtask

  task automatic wait_drained();
    item_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // The register is only written while the core is idle.
  task automatic write_brk_vector(input logic [15:0] vec);
    wait_drained();
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= REG_BRK_VECTOR;
    pwdata <= {16'd0, vec};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sh_brk_vec = vec;
  endtask

  // Result stall: random most of the time, released during the quiet stretch.
  always @(negedge clk) result_stall <= !quiet_mode && ($urandom_range(99) < 11);

  // Compares every accepted result against the oldest pending expectation.
  always @(posedge clk) begin
    result_t exp_r;
    if (!rst && result_valid && !result_stall) begin
      if (expected_results.size() == 0) begin
        $error("result transaction with no expectation pending");
        mismatch_count++;
      end else begin
        exp_r = expected_results.pop_front();
        if (result.write_enable !== exp_r.write_enable) begin
          $error("write_enable exp %0h got %0h", exp_r.write_enable, result.write_enable);
          mismatch_count++;
        end
        if (result.write_address !== exp_r.write_address) begin
          $error("write_address exp %0h got %0h", exp_r.write_address, result.write_address);
          mismatch_count++;
        end
        if (result.write_data !== exp_r.write_data) begin
          $error("write_data exp %0h got %0h", exp_r.write_data, result.write_data);
          mismatch_count++;
        end
        if (result.new_pc !== exp_r.new_pc) begin
          $error("new_pc exp %0h got %0h", exp_r.new_pc, result.new_pc);
          mismatch_count++;
        end
        if (result.flags_out !== exp_r.flags_out) begin
          $error("flags_out exp %0h got %0h", exp_r.flags_out, result.flags_out);
          mismatch_count++;
        end
        if (result.acc_out !== exp_r.acc_out) begin
          $error("acc_out exp %0h got %0h", exp_r.acc_out, result.acc_out);
          mismatch_count++;
        end
        if (result.x_out !== exp_r.x_out) begin
          $error("x_out exp %0h got %0h", exp_r.x_out, result.x_out);
          mismatch_count++;
        end
        if (result.y_out !== exp_r.y_out) begin
          $error("y_out exp %0h got %0h", exp_r.y_out, result.y_out);
          mismatch_count++;
        end
        if (result.sp_out !== exp_r.sp_out) begin
          $error("sp_out exp %0h got %0h", exp_r.sp_out, result.sp_out);
          mismatch_count++;
        end
      end
    end
  end

  // Directed: field extremes, every opcode including the unused codes, stack wrap,
  // the pushed and pulled status bits, BRK/RTI and JSR/RTS round trips.
  task automatic test_directed();
    item_t it;
    send_op(OP_LDA, 8'h7F);
    send_op(OP_ADC, 8'h01);       // signed overflow into negative
    send_op(OP_SBC, 8'hFF);
    send_op(OP_CMP, 8'h00);
    send_op(OP_BMI, 8'h80);       // most negative offset
    send_op(OP_BPL, 8'h7F);
    send_op(OP_PHP, 8'h00);
    send_op(OP_PLP, 8'h00);       // bits 5 and 4 are kept
    it = '0;
    it.opcode = OP_JSR;
    it.effective_address = 16'hFFFF;
    it.next_pc = 16'h0000;        // return address wraps below zero
    it.accumulator_mode = 1'b1;
    send_instruction(it);
    send_op(OP_RTS, 8'h00);
    send_op(OP_BRK, 8'h00);
    send_op(OP_RTI, 8'h00);
    send_op(OP_LDX, 8'h00);
    send_op(OP_TXS, 8'h00);       // SP to zero, the next push wraps
    send_op(OP_PHA, 8'h00);
    send_op(OP_PLA, 8'h00);
    send_op(OP_ROR, 8'hFF);
    send_op(6'd63, 8'hFF);        // unused code acts as NOP
    for (int op = 0; op < 64; op++) send_op(6'(op), 8'($urandom));
  endtask

  function automatic logic [5:0] pick_opcode();
    return (($urandom_range(9) == 0) ? 6'($urandom_range(63, 56)) : 6'($urandom_range(55)));
  endfunction

  task automatic test_random(input int count);
    item_t it;
    for (int i = 0; i < count; i++) begin
      it.operand = 8'($urandom);
      it.effective_address = 16'($urandom);
      it.accumulator_mode = 1'($urandom);
      it.next_pc = 16'($urandom);
      it.opcode = pick_opcode();
      // Bias toward full-range operands so carry and sign cases appear often.
      if ($urandom_range(3) == 0) it.operand = ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
      send_instruction(it);
    end
  endtask

  // Subroutine and interrupt frames, each closed by a randomly chosen RTS or RTI, with random content between them.
  task automatic test_call_frames(input int count);
    for (int i = 0; i < count; i++) begin
      send_op(($urandom_range(1) != 0) ? OP_JSR : OP_BRK, 8'($urandom));
      test_random($urandom_range(3));
      send_op(OP_PHA, 8'h00);
      send_op(OP_PLA, 8'h00);
      send_op(($urandom_range(1) != 0) ? OP_RTS : OP_RTI, 8'h00);
    end
  endtask

  initial begin
    logic [15:0] vectors [4];
    sh_a = 8'h00; sh_x = 8'h00; sh_y = 8'h00;
    sh_sp = SpReset; sh_p = PReset;
    sh_brk_vec = 16'h0000;
    for (int i = 0; i < 256; i++) sh_stack[i] = 8'h00;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed();
    vectors = '{16'hFFFF, 16'h0000, 16'hA55A, 16'($urandom)};
    foreach (vectors[v]) begin
      write_brk_vector(vectors[v]);
      test_call_frames(20);
      test_random(70);
    end
    // The sender holds off until every expected result is back, then runs without idling.
    wait_drained();
    quiet_mode = 1'b1;
    test_random(150);
    quiet_mode = 1'b0;
    test_random(60);

    wait_drained();
    if (mismatch_count == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #2ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

/* cpu6502_instruction_execute_core.f */
hw/rtl/cpe_pkg.sv
hw/rtl/cpe_ram.sv
hw/rtl/cpe_exec.sv
hw/rtl/cpe_outq.sv
hw/rtl/cpu6502_instruction_execute_core.sv
hw/rtl/cpe_checker.sv
dv/cpu6502_instruction_execute_core_tb.sv
